// File: src/mst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants and types of the MM:SS timer with alarm: button codes,
// digit widths and limits, register defaults and the digit cell control word.
// ----------------------------------------------------------------------------
package mst_pkg;

	// Default width of the hold, tick and alarm counters.
	localparam int unsigned MST_COUNTER_WIDTH = 16;

	// Configuration registers.
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_HOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_TICKS  = 2'd2;

	localparam logic [CFG_W-1:0] RST_REPEAT_HOLD = 16'd40000;
	localparam logic [CFG_W-1:0] RST_TICKS_PER_S = 16'd1000;
	localparam logic [CFG_W-1:0] RST_ALARM_TICKS = 16'd5000;

	// Button codes carried by a poll.
	localparam logic [7:0] BTN_UP       = 8'd16;
	localparam logic [7:0] BTN_DOWN     = 8'd32;
	localparam logic [7:0] BTN_START    = 8'd64;
	localparam logic [7:0] BTN_CLEAR    = 8'd128;
	localparam logic [7:0] BTN_RELEASED = 8'd0;

	// Item kinds.
	localparam logic KIND_POLL = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Digit widths and the largest value each digit holds.
	localparam int unsigned ONES_W   = 4;
	localparam int unsigned TENS_W   = 3;
	localparam int unsigned ONES_MAX = 9;
	localparam int unsigned TENS_MAX = 5;

	// Control word broadcast to every digit cell.
	typedef struct packed {
		logic step;   // a step (button or one-second) enters the chain
		logic up;     // 1 counts up, 0 counts down
		logic clr;    // clear the digit
	} step_t;

	// One result item.
	typedef struct packed {
		logic [ONES_W-1:0] seconds_ones;
		logic [TENS_W-1:0] seconds_tens;
		logic [ONES_W-1:0] minutes_ones;
		logic [TENS_W-1:0] minutes_tens;
		logic              is_running;
		logic              alarm_lit;
	} result_t;

endpackage
`default_nettype wire

// File: src/mst_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_if
// Valid/ready channels of the timer: the input item channel and the result
// item channel.
// ----------------------------------------------------------------------------
interface mst_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] buttons;

	modport source (output valid, output kind, output buttons, input ready);
	modport sink   (input valid, input kind, input buttons, output ready);
endinterface

interface mst_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] seconds_ones;
	logic [2:0] seconds_tens;
	logic [3:0] minutes_ones;
	logic [2:0] minutes_tens;
	logic       is_running;
	logic       alarm_lit;

	modport source (output valid, output seconds_ones, output seconds_tens,
		output minutes_ones, output minutes_tens, output is_running,
		output alarm_lit, input ready);
	modport sink   (input valid, input seconds_ones, input seconds_tens,
		input minutes_ones, input minutes_tens, input is_running,
		input alarm_lit, output ready);
endinterface
`default_nettype wire

// File: src/mst_digit_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_digit_cell
// One BCD digit of the time. A step arrives on carry_in, the digit moves up
// or down with wrap, and the carry or borrow passes on to the next digit.
// ----------------------------------------------------------------------------
module mst_digit_cell #(
	parameter int unsigned WIDTH     = 4,
	parameter int unsigned MAX_DIGIT = 9
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mst_pkg::step_t      ctrl,
	input  wire logic                carry_in,
	output logic                     carry_out,
	output logic [WIDTH-1:0]         digit_next
);
	import mst_pkg::*;

	localparam logic [WIDTH-1:0] TOP = WIDTH'(MAX_DIGIT);

	logic [WIDTH-1:0] digit_q;
	logic             at_edge;

	// The digit wraps at its top when counting up and at zero when down.
	assign at_edge   = ctrl.up ? (digit_q == TOP) : (digit_q == '0);
	assign carry_out = carry_in && at_edge;

	always_comb begin
		if (ctrl.clr) begin
			digit_next = '0;
		end else if (carry_in) begin
			if (ctrl.up) begin
				digit_next = at_edge ? '0 : digit_q + WIDTH'(1);
			end else begin
				digit_next = at_edge ? TOP : digit_q - WIDTH'(1);
			end
		end else begin
			digit_next = digit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			digit_q <= digit_next;
		end
	end

endmodule
`default_nettype wire

// File: src/minute_second_timer_with_alarm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// minute_second_timer_with_alarm
// MM:SS timer held in a chain of four BCD digit cells, with set buttons,
// start/stop, clear and an overflow alarm lit for a set number of ticks.
// ----------------------------------------------------------------------------
// Output: the result of an accepted item is registered in the output
// register, or in the skid register while the output is held.
// Throughput: one item per cycle while the skid register is empty; the carry
// ripples through the four digit cells and the counter compares within that
// cycle, and a skid register keeps input open while one result waits.
// Reset: clears time, counters and flags; registers return to their defaults.
// ----------------------------------------------------------------------------
module minute_second_timer_with_alarm #(
	parameter int unsigned COUNTER_WIDTH = mst_pkg::MST_COUNTER_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mst_pkg::CFG_W-1:0]     cfg_data,
	mst_req_if.sink                            req,
	mst_rsp_if.source                          rsp
);
	import mst_pkg::*;

	localparam int unsigned CW    = COUNTER_WIDTH;
	localparam int unsigned CMP_W = (CW > CFG_W) ? CW : CFG_W;

	// Configuration registers.
	logic [CFG_W-1:0] repeat_hold_q, ticks_per_s_q, alarm_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_hold_q <= RST_REPEAT_HOLD;
			ticks_per_s_q <= RST_TICKS_PER_S;
			alarm_ticks_q <= RST_ALARM_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REPEAT_HOLD: repeat_hold_q <= cfg_data;
				REG_TICKS_PER_S: ticks_per_s_q <= cfg_data;
				REG_ALARM_TICKS: alarm_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state.
	logic [CW-1:0] up_hold_q, down_hold_q, tick_count_q, alarm_count_q;
	logic          running_q, alarm_on_q, ticks_en_q, start_latch_q, reset_latch_q;

	// Output register and skid register.
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;

	logic accept, out_free;
	assign req.ready = !skid_valid_q;
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Item decode.
	logic poll, tick, is_up, is_down, is_start, is_clear, is_rel;
	assign poll     = accept && (req.kind == KIND_POLL);
	assign tick     = accept && (req.kind == KIND_TICK) && ticks_en_q;
	assign is_up    = poll && (req.buttons == BTN_UP);
	assign is_down  = poll && (req.buttons == BTN_DOWN);
	assign is_start = poll && (req.buttons == BTN_START);
	assign is_clear = poll && (req.buttons == BTN_CLEAR);
	assign is_rel   = poll && (req.buttons == BTN_RELEASED);

	// Counter increments and threshold hits.
	logic [CW-1:0] up_inc, down_inc, tick_inc, alarm_base, alarm_inc;
	logic          up_hit, down_hit, tick_hit, alarm_hit;
	assign up_inc   = up_hold_q + CW'(1);
	assign down_inc = down_hold_q + CW'(1);
	assign tick_inc = tick_count_q + CW'(1);
	assign up_hit   = CMP_W'(up_inc) >= CMP_W'(repeat_hold_q);
	assign down_hit = CMP_W'(down_inc) >= CMP_W'(repeat_hold_q);
	assign tick_hit = CMP_W'(tick_inc) >= CMP_W'(ticks_per_s_q);

	// Step control for the digit chain.
	logic  sec_step, wrap, clear_now;
	step_t ctrl;
	assign sec_step  = tick && running_q && tick_hit;
	assign clear_now = is_clear && !reset_latch_q;
	assign ctrl.up   = !is_down;
	assign ctrl.step = (is_up && up_hit) || (is_down && down_hit) || sec_step;
	assign ctrl.clr  = clear_now;

	// Digit chain: seconds ones to minutes tens.
	logic [3:0] carry;
	logic [ONES_W-1:0] so_next, mo_next;
	logic [TENS_W-1:0] st_next, mt_next;

	mst_digit_cell #(.WIDTH(ONES_W), .MAX_DIGIT(ONES_MAX)) u_sec_ones (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .carry_in(ctrl.step),
		.carry_out(carry[0]), .digit_next(so_next));
	mst_digit_cell #(.WIDTH(TENS_W), .MAX_DIGIT(TENS_MAX)) u_sec_tens (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .carry_in(carry[0]),
		.carry_out(carry[1]), .digit_next(st_next));
	mst_digit_cell #(.WIDTH(ONES_W), .MAX_DIGIT(ONES_MAX)) u_min_ones (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .carry_in(carry[1]),
		.carry_out(carry[2]), .digit_next(mo_next));
	mst_digit_cell #(.WIDTH(TENS_W), .MAX_DIGIT(TENS_MAX)) u_min_tens (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .carry_in(carry[2]),
		.carry_out(carry[3]), .digit_next(mt_next));

	// Only a running tick counts up past 59:59 into the alarm.
	assign wrap = sec_step && carry[3];

	// The alarm counts on ticks while lit and stopped, from zero on the wrap tick.
	logic alarm_count_en;
	assign alarm_count_en = tick && (wrap || (alarm_on_q && !running_q));
	assign alarm_base     = wrap ? '0 : alarm_count_q;
	assign alarm_inc      = alarm_base + CW'(1);
	assign alarm_hit      = CMP_W'(alarm_inc) >= CMP_W'(alarm_ticks_q);

	// Next flags, as seen by the result of this item.
	logic running_d, alarm_on_d;
	always_comb begin
		running_d  = running_q;
		alarm_on_d = alarm_on_q;
		if (is_start && !start_latch_q) begin
			running_d = !running_q;
		end
		if (clear_now) begin
			running_d  = 1'b0;
			alarm_on_d = 1'b0;
		end
		if (wrap) begin
			running_d  = 1'b0;
			alarm_on_d = 1'b1;
		end
		if (alarm_count_en && alarm_hit) begin
			alarm_on_d = 1'b0;
		end
	end

	// Counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_hold_q     <= '0;
			down_hold_q   <= '0;
			tick_count_q  <= '0;
			alarm_count_q <= '0;
			running_q     <= 1'b0;
			alarm_on_q    <= 1'b0;
			ticks_en_q    <= 1'b0;
			start_latch_q <= 1'b0;
			reset_latch_q <= 1'b0;
		end else begin
			running_q  <= running_d;
			alarm_on_q <= alarm_on_d;
			if (is_up || is_down || is_start || is_clear) begin
				ticks_en_q <= 1'b1;
			end
			if (is_up) begin
				up_hold_q <= up_hit ? '0 : up_inc;
			end
			if (is_down) begin
				down_hold_q <= down_hit ? '0 : down_inc;
			end
			if (is_start) begin
				start_latch_q <= 1'b1;
			end
			if (is_clear) begin
				reset_latch_q <= 1'b1;
			end
			if (is_rel) begin
				start_latch_q <= 1'b0;
				reset_latch_q <= 1'b0;
			end
			if (clear_now) begin
				tick_count_q <= '0;
			end else if (tick && running_q) begin
				tick_count_q <= tick_hit ? '0 : tick_inc;
			end
			if (alarm_count_en) begin
				alarm_count_q <= alarm_inc;
			end
		end
	end

	// Result of the accepted item.
	result_t res;
	assign res.seconds_ones = so_next;
	assign res.seconds_tens = st_next;
	assign res.minutes_ones = mo_next;
	assign res.minutes_tens = mt_next;
	assign res.is_running   = running_d;
	assign res.alarm_lit    = alarm_on_d;

	// Output register with a skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (out_free && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.seconds_ones = out_q.seconds_ones;
	assign rsp.seconds_tens = out_q.seconds_tens;
	assign rsp.minutes_ones = out_q.minutes_ones;
	assign rsp.minutes_tens = out_q.minutes_tens;
	assign rsp.is_running   = out_q.is_running;
	assign rsp.alarm_lit    = out_q.alarm_lit;

endmodule
`default_nettype wire
